// ===== rtl/chacha_pkg.sv =====
// Shared types, constants and round functions for the ChaCha permutation core.
// Depends on nothing; every rtl module refers to it by scoped names.
package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
  localparam int unsigned WORD_W            = 32;
  localparam int unsigned NUM_WORDS         = 16;
  localparam int unsigned DATA_W            = WORD_W * NUM_WORDS;

  // Rotation amounts of the four add-xor-rotate steps of a quarter-round.
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  // Word i of the block sits in bits 32i+31..32i, matching the lane packing.
  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                             input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // One half of all four quarter-rounds of a column or diagonal round.
  // The first half does the steps that rotate by 16 and 12, the second half
  // those that rotate by 8 and 7.
  function automatic state_t half_qr(input state_t s, input logic diag,
                                     input logic second);
    state_t            r;
    logic [1:0]        ib;
    logic [1:0]        ic;
    logic [1:0]        id;
    logic [3:0]        a;
    logic [3:0]        b;
    logic [3:0]        c;
    logic [3:0]        d;
    logic [WORD_W-1:0] va;
    logic [WORD_W-1:0] vb;
    logic [WORD_W-1:0] vc;
    logic [WORD_W-1:0] vd;
    r = s;
    for (int q = 0; q < 4; q++) begin
      ib = diag ? 2'(q + 1) : 2'(q);
      ic = diag ? 2'(q + 2) : 2'(q);
      id = diag ? 2'(q + 3) : 2'(q);
      a  = {2'b00, 2'(q)};
      b  = {2'b01, ib};
      c  = {2'b10, ic};
      d  = {2'b11, id};
      va = s[a];
      vb = s[b];
      vc = s[c];
      vd = s[d];
      if (!second) begin
        va = va + vb;
        vd = rotl(vd ^ va, ROT_A);
        vc = vc + vd;
        vb = rotl(vb ^ vc, ROT_B);
      end else begin
        va = va + vb;
        vd = rotl(vd ^ va, ROT_C);
        vc = vc + vd;
        vb = rotl(vb ^ vc, ROT_D);
      end
      r[a] = va;
      r[b] = vb;
      r[c] = vc;
      r[d] = vd;
    end
    return r;
  endfunction

endpackage

// ===== rtl/chacha_step.sv =====
// One pipeline stage: half of a column or diagonal round over the whole block.
// Depends on chacha_pkg for the state type and the half-round function.
module chacha_step #(
  parameter bit DIAG   = 1'b0,
  parameter bit SECOND = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  chacha_pkg::state_t in_state,
  output logic              out_valid,
  output chacha_pkg::state_t out_state
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_state <= chacha_pkg::half_qr(in_state, DIAG, SECOND);
    end
  end

endmodule

// ===== rtl/chacha_skid.sv =====
// Output register with a one-entry skid buffer behind the round pipeline.
// Depends on chacha_pkg for the state type.
module chacha_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  chacha_pkg::state_t in_state,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output chacha_pkg::state_t out_state
);

  logic               sk_valid;
  chacha_pkg::state_t sk_state;
  logic               out_free;
  logic               fire;

  // The pipeline only moves while the skid entry is empty, so in_ready is
  // a plain register output and the receiver's ready never reaches it.
  assign in_ready = !sk_valid;
  assign fire     = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_free) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= fire;
      end
    end else if (fire) begin
      sk_valid <= 1'b1;
    end
    if (out_free) begin
      out_state <= sk_valid ? sk_state : in_state;
    end
    if (!out_free && fire) begin
      sk_state <= in_state;
    end
  end

endmodule

// ===== rtl/chacha_block_permutation_core.sv =====
// Top level of the ChaCha block permutation core: round pipeline and output buffer.
// Depends on chacha_pkg, chacha_step and chacha_skid.
//
// Usage. A block of sixteen 32-bit words arrives as one beat on the slave
// stream (s_tvalid, s_tready, s_tdata) and leaves, permuted, as one beat on
// the master stream (m_tvalid, m_tready, m_tdata). Word i occupies bits
// 32i+31..32i of tdata in both directions, so lane j holds word 2j in its
// low half and word 2j+1 in its high half. No feed-forward addition of the
// input is made; the caller adds the input words itself if it wants the
// ChaCha keystream block.
// Pipeline. Each double round is four pipeline stages: first
// and second half of the column round, then of the diagonal round, each
// stage doing two dependent 32-bit add-xor-rotate steps of all four
// quarter-rounds side by side. A beat passes through every stage and then
// the output register to m_tvalid, and while m_tready stays high one beat
// can be taken and delivered every cycle.
// Reset clears every valid bit in the pipeline and the output buffer; data
// registers are not reset. The core holds no other state.
// Stalls. When the receiver holds m_tready low the result stays on
// m_tdata and one further beat is caught in a skid entry; the whole
// pipeline then freezes and s_tready drops until that entry drains. Nothing
// is lost or repeated.
module chacha_block_permutation_core #(
  parameter int unsigned DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // Fields from bit 0 up: lane0_in .. lane7_in, 64 bits each.
  input  logic [chacha_pkg::DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // Fields from bit 0 up: lane0_out .. lane7_out, 64 bits each.
  output logic [chacha_pkg::DATA_W-1:0] m_tdata
);

  localparam int unsigned NUM_STAGES = 4 * DOUBLE_ROUNDS;

  logic               pipe_en;
  logic               st_valid [NUM_STAGES+1];
  chacha_pkg::state_t st_state [NUM_STAGES+1];
  chacha_pkg::state_t out_state;

  // Slot 0 is the incoming beat itself; the first stage works on it directly.
  assign st_valid[0] = s_tvalid;
  assign st_state[0] = s_tdata;
  assign s_tready    = pipe_en;

  // Stage k is in double round k/4; bit 1 of k picks column or diagonal,
  // bit 0 picks the first or second half of the quarter-rounds.
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam bit StageDiag   = ((k / 2) % 2) == 1;
    localparam bit StageSecond = (k % 2) == 1;
    chacha_step #(
      .DIAG   (StageDiag),
      .SECOND (StageSecond)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .in_valid  (st_valid[k]),
      .in_state  (st_state[k]),
      .out_valid (st_valid[k+1]),
      .out_state (st_state[k+1])
    );
  end

  chacha_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[NUM_STAGES]),
    .in_state  (st_state[NUM_STAGES]),
    .in_ready  (pipe_en),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_state (out_state)
  );

  assign m_tdata = out_state;

`ifndef SYNTHESIS
  // A full skid entry only exists behind a held output beat.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |-> m_tvalid)
    else $error("skid entry full while output register is empty");

  // The skid entry only fills when the receiver stalled a valid beat.
  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $fell(pipe_en) |-> $past(m_tvalid && !m_tready))
    else $error("skid entry filled without a stalled output beat");

  // While the pipeline is frozen its last stage must not change.
  a_last_stage_frozen: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |=> $stable(st_valid[NUM_STAGES]) && $stable(st_state[NUM_STAGES]))
    else $error("last pipeline stage changed during a stall");
`endif

endmodule
